// ===== rtl/dat_pkg.sv =====
// Package for the dual answer-tone detector: payload types, coefficients,
// decision codes and register indexes. No dependencies.
package dat_pkg;

    localparam int unsigned HistDepth = 24;
    localparam int unsigned HistAw    = 5;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_of_block;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  decision;
        logic [21:0] total_energy;
        logic [21:0] energy_tone_a;
        logic [21:0] energy_tone_b;
    } out_beat_t;

    typedef enum logic [2:0] {
        DEC_NOSIG   = 3'd0,
        DEC_A       = 3'd1,
        DEC_A_CONF  = 3'd2,
        DEC_B       = 3'd3,
        DEC_B_CONF  = 3'd4,
        DEC_OTHER   = 3'd5
    } decision_t;

    localparam logic [1:0] REG_RATIO        = 2'd0;
    localparam logic [1:0] REG_ENERGY_FLOOR = 2'd1;
    localparam logic [1:0] REG_HOLD_LIMIT   = 2'd2;

    localparam logic [7:0]  RATIO_RESET        = 8'd226;
    localparam logic [21:0] ENERGY_FLOOR_RESET = 22'd1;
    localparam logic [14:0] HOLD_LIMIT_RESET   = 15'd1280;

    localparam logic [7:0] SM_KEEP = 8'd205;
    localparam logic [7:0] SM_TAKE = 8'd51;

    // Coefficient for (section, tap). Sections 0..2 bandpass, 3..5 notches.
    // Taps: 0 x[n], 1 x[n-1], 2 x[n-2], 3 y[n-1], 4 y[n-2]; the sign of
    // the feedback taps is folded in so every tap adds.
    function automatic logic signed [17:0] coef(input logic [2:0] sec,
                                                input logic [2:0] tap);
        logic signed [17:0] c;
        c = '0;
        case ({sec, tap})
            {3'd0, 3'd0}: c = 18'sd8192;
            {3'd0, 3'd1}: c = 18'sd0;
            {3'd0, 3'd2}: c = -18'sd8192;
            {3'd0, 3'd3}: c = -18'sd1495;
            {3'd0, 3'd4}: c = -18'sd6862;
            {3'd1, 3'd0}: c = 18'sd8192;
            {3'd1, 3'd1}: c = -18'sd16384;
            {3'd1, 3'd2}: c = 18'sd8192;
            {3'd1, 3'd3}: c = 18'sd1140;
            {3'd1, 3'd4}: c = -18'sd7508;
            {3'd2, 3'd0}: c = 18'sd8192;
            {3'd2, 3'd1}: c = 18'sd16384;
            {3'd2, 3'd2}: c = 18'sd8192;
            {3'd2, 3'd3}: c = -18'sd4185;
            {3'd2, 3'd4}: c = -18'sd7531;
            {3'd3, 3'd0}: c = 18'sd16384;
            {3'd3, 3'd1}: c = 18'sd2571;
            {3'd3, 3'd2}: c = 18'sd16384;
            {3'd3, 3'd3}: c = -18'sd2314;
            {3'd3, 3'd4}: c = -18'sd13271;
            {3'd4, 3'd0}: c = 18'sd16384;
            {3'd4, 3'd1}: c = -18'sd5126;
            {3'd4, 3'd2}: c = 18'sd16384;
            {3'd4, 3'd3}: c = 18'sd4613;
            {3'd4, 3'd4}: c = -18'sd13271;
            {3'd5, 3'd0}: c = 18'sd16384;
            {3'd5, 3'd1}: c = 18'sd6393;
            {3'd5, 3'd2}: c = 18'sd16384;
            {3'd5, 3'd3}: c = -18'sd5753;
            {3'd5, 3'd4}: c = -18'sd13271;
            default:      c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/dat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dat_ram #(
    parameter int unsigned Width = 16,
    parameter int unsigned Depth = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dat_filter.sv =====
// Six biquad sections on one shared MAC; history lives in a RAM.
// Depends on dat_pkg and dat_ram.
module dat_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] x_in,
    output logic               done,
    output logic signed [15:0] band,
    output logic signed [15:0] ya,
    output logic signed [15:0] yc
);
    import dat_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_WB, S_FIN} st_t;

    // History per section s at 4*s: x1, x2, y1, y2. RAM has no reset; a
    // clearing pass after reset writes zeros.
    st_t                 st_reg;
    logic [2:0]          sec_reg;
    logic [2:0]          tap_reg;
    logic [HistAw-1:0]   clr_reg;
    logic                clr_busy_reg;
    logic signed [31:0]  acc_reg;
    logic signed [15:0]  xs_reg;
    logic signed [15:0]  band_reg, ya_reg, yc_reg;
    logic signed [15:0]  h_reg [4];
    logic                done_reg;
    logic [1:0]          wb_reg;
    logic signed [15:0]  yout_reg;

    logic                we;
    logic [HistAw-1:0]   waddr, raddr;
    logic [15:0]         wdata, rdata;
    logic signed [15:0]  op;
    logic signed [33:0]  prod;
    logic [31:0]         acc_next;
    logic signed [15:0]  y_raw;
    logic signed [15:0]  y_post;

    dat_ram #(.Width(16), .Depth(HistDepth)) u_hist (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        case (tap_reg)
            3'd0:    op = xs_reg;
            3'd1:    op = h_reg[0];
            3'd2:    op = h_reg[1];
            3'd3:    op = h_reg[2];
            3'd4:    op = h_reg[3];
            default: op = '0;
        endcase
        prod     = coef(sec_reg, tap_reg) * op;
        acc_next = acc_reg + prod[31:0];
        // bandpass: bits 14..28 doubled; notch: bits 14..29
        if (sec_reg < 3'd3)
        begin
            y_raw = {acc_reg[28:14], 1'b0};
        end
        else
        begin
            y_raw = acc_reg[29:14];
        end
        if (sec_reg == 3'd2 || sec_reg > 3'd2)
        begin
            y_post = y_raw;
        end
        else
        begin
            y_post = y_raw >>> 3;
        end
    end

    // write back x1<=x, x2<=x1, y1<=y, y2<=y1 in turn
    always_comb
    begin
        we    = clr_busy_reg || st_reg == S_WB;
        waddr = clr_busy_reg ? clr_reg : HistAw'({sec_reg, wb_reg});
        case (wb_reg)
            2'd0:    wdata = xs_reg;
            2'd1:    wdata = h_reg[0];
            2'd2:    wdata = y_raw;
            default: wdata = h_reg[2];
        endcase
        if (clr_busy_reg)
        begin
            wdata = '0;
        end
        raddr = HistAw'({sec_reg, tap_reg[1:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            sec_reg      <= '0;
            tap_reg      <= '0;
            wb_reg       <= '0;
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == HistAw'(HistDepth - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        xs_reg  <= x_in >>> 3;
                        sec_reg <= '0;
                        tap_reg <= '0;
                        st_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    // tap_reg counts reads 0..3; data lands in the cycle after its read
                    if (tap_reg != 3'd0)
                    begin
                        h_reg[tap_reg[1:0] - 2'd1] <= rdata;
                    end
                    if (tap_reg == 3'd4)
                    begin
                        tap_reg <= '0;
                        acc_reg <= '0;
                        st_reg  <= S_MAC;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 3'd1;
                    end
                end
                S_MAC:
                begin
                    acc_reg <= acc_next;
                    if (tap_reg == 3'd4)
                    begin
                        wb_reg <= '0;
                        st_reg <= S_WB;
                    end
                    tap_reg <= tap_reg + 3'd1;
                end
                S_WB:
                begin
                    wb_reg <= wb_reg + 2'd1;
                    if (wb_reg == 2'd3)
                    begin
                        yout_reg <= y_post;
                        st_reg   <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    tap_reg <= '0;
                    st_reg  <= S_READ;
                    sec_reg <= sec_reg + 3'd1;
                    case (sec_reg)
                        3'd0, 3'd1:
                        begin
                            xs_reg <= yout_reg;
                        end
                        3'd2:
                        begin
                            xs_reg   <= yout_reg;
                            band_reg <= yout_reg;
                        end
                        3'd3:
                        begin
                            ya_reg <= yout_reg;
                            xs_reg <= band_reg;
                        end
                        3'd4:
                        begin
                            xs_reg <= yout_reg;
                        end
                        default:
                        begin
                            yc_reg   <= yout_reg;
                            done_reg <= 1'b1;
                            st_reg   <= S_IDLE;
                        end
                    endcase
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign band = band_reg;
    assign ya   = ya_reg;
    assign yc   = yc_reg;

endmodule

// ===== rtl/dual_answer_tone_detector_top.sv =====
// Top level of the dual answer-tone detector: handshakes, registers,
// energy smoothing and decision. Depends on dat_pkg and dat_filter.
//
// Usage: offer samples on the in channel (valid/ready). Each sample runs
// through three bandpass and three notch sections on one shared MAC whose
// history sits in a 24-entry RAM. Each section reads its four history
// words, runs its five taps, writes back four words and hands off; then
// comes energy smoothing, so a new sample is taken only once the previous
// one is through. A sample with last_of_block set yields one result beat
// on the out channel; others yield none.
// The output register holds a result until taken; samples without
// last_of_block keep flowing meanwhile, but a sample that ends a block
// waits with in_ready low until the first result is gone.
// After reset the history RAM is cleared and in_ready stays low while
// T_BOOT waits out the clearing pass; configuration writes are taken at
// any time the block is idle. Registers: 0 ratio, 1 energy floor, 2 hold_limit.
module dual_answer_tone_detector_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dat_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dat_pkg::out_beat_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data
);
    import dat_pkg::*;

    typedef enum logic [2:0] {T_BOOT, T_IDLE, T_FILT, T_E1, T_E2, T_DEC, T_WAIT} st_t;

    st_t                st_reg;
    logic [7:0]         ratio_reg;
    logic [21:0]        energy_floor_reg;
    logic [14:0]        hold_limit_reg;
    logic [21:0]        sm_t_reg, sm_a_reg, sm_b_reg;
    logic [15:0]        hca_reg, hcb_reg;
    logic               last_reg;
    logic [22:0]        tot_reg, ra_reg, rb_reg;
    logic [5:0]         boot_reg;
    logic               ov_reg;
    out_beat_t          od_reg;
    logic               start;
    logic               fdone;
    logic signed [15:0] band, ya, yc;
    logic [31:0]        sqx, sqa, sqc;
    logic [22:0]        tot, fa, fc;
    logic [29:0]        thr;
    logic [21:0]        nt, na, nb;
    decision_t          dec;
    logic [15:0]        hca_next, hcb_next;

    assign start    = in_valid && in_ready;
    assign in_ready = st_reg == T_IDLE;

    dat_filter u_filt (
        .clk(clk), .rst_n(rst_n), .start(start), .x_in(in_data.sample),
        .done(fdone), .band(band), .ya(ya), .yc(yc)
    );

    // energy of a full-scale negative word reaches 2^22, hence 23-bit input
    function automatic logic [21:0] smooth(input logic [21:0] acc,
                                           input logic [22:0] x);
        logic [30:0] s;
        s = 31'(SM_KEEP) * 31'(acc) + 31'(SM_TAKE) * 31'(x);
        return s[29:8];
    endfunction

    always_comb
    begin
        sqx = 32'(band) * 32'(band);
        sqa = 32'(ya) * 32'(ya);
        sqc = 32'(yc) * 32'(yc);
        tot = sqx[30:8];
        fa  = sqa[30:8];
        fc  = sqc[30:8];
        nt  = smooth(sm_t_reg, tot_reg);
        na  = smooth(sm_a_reg, ra_reg);
        nb  = smooth(sm_b_reg, rb_reg);
        thr = ratio_reg * sm_t_reg;
        hca_next = hca_reg;
        hcb_next = hcb_reg;
        if (sm_t_reg < energy_floor_reg)
        begin
            dec = DEC_NOSIG; hca_next = '0; hcb_next = '0;
        end
        else if (sm_a_reg > thr[29:8])
        begin
            if ($signed(hca_reg) < $signed({1'b0, hold_limit_reg}))
            begin
                dec = DEC_A; hcb_next = '0;
            end
            else
            begin
                dec = DEC_A_CONF; hca_next = '0; hcb_next = '0;
            end
        end
        else if (sm_b_reg > thr[29:8])
        begin
            if ($signed(hcb_reg) < $signed({1'b0, hold_limit_reg}))
            begin
                dec = DEC_B; hca_next = '0;
            end
            else
            begin
                dec = DEC_B_CONF; hca_next = '0; hcb_next = '0;
            end
        end
        else
        begin
            dec = DEC_OTHER; hca_next = '0; hcb_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= T_BOOT;
            boot_reg         <= '0;
            ratio_reg        <= RATIO_RESET;
            energy_floor_reg <= ENERGY_FLOOR_RESET;
            hold_limit_reg   <= HOLD_LIMIT_RESET;
            sm_t_reg         <= '0;
            sm_a_reg         <= '0;
            sm_b_reg         <= '0;
            hca_reg          <= '0;
            hcb_reg          <= '0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATIO:        ratio_reg        <= cfg_data[7:0];
                    REG_ENERGY_FLOOR: energy_floor_reg <= cfg_data;
                    REG_HOLD_LIMIT:   hold_limit_reg   <= cfg_data[14:0];
                    default:          ;
                endcase
            end
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                T_BOOT:
                begin
                    // wait out the history clearing pass
                    boot_reg <= boot_reg + 6'd1;
                    if (boot_reg == 6'd30)
                    begin
                        st_reg <= T_IDLE;
                    end
                end
                T_IDLE:
                begin
                    if (start)
                    begin
                        last_reg <= in_data.last_of_block;
                        hca_reg  <= hca_reg + 16'd1;
                        hcb_reg  <= hcb_reg + 16'd1;
                        st_reg   <= T_FILT;
                    end
                end
                T_FILT:
                begin
                    if (fdone)
                    begin
                        st_reg <= T_E1;
                    end
                end
                T_E1:
                begin
                    tot_reg <= tot;
                    ra_reg  <= (fa > tot) ? '0 : tot - fa;
                    rb_reg  <= (fc > tot) ? '0 : tot - fc;
                    st_reg  <= T_E2;
                end
                T_E2:
                begin
                    sm_t_reg <= nt;
                    sm_a_reg <= na;
                    sm_b_reg <= nb;
                    st_reg   <= last_reg ? T_WAIT : T_IDLE;
                end
                T_WAIT:
                begin
                    // hold until the output register is free
                    if (!ov_reg || out_ready)
                    begin
                        st_reg <= T_DEC;
                    end
                end
                T_DEC:
                begin
                    ov_reg                <= 1'b1;
                    od_reg.decision       <= dec;
                    od_reg.total_energy   <= sm_t_reg;
                    od_reg.energy_tone_a  <= sm_a_reg;
                    od_reg.energy_tone_b  <= sm_b_reg;
                    hca_reg               <= hca_next;
                    hcb_reg               <= hcb_next;
                    st_reg                <= T_IDLE;
                end
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

// ===== rtl/dat_checker.sv =====
// Port-level checks for the dual answer-tone detector, bound to the top.
// Depends on dat_pkg.
module dat_assert (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dat_pkg::out_beat_t out_data
);
    import dat_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.decision <= DEC_OTHER)
        else $error("decision code out of range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while busy");

    a_nosig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.total_energy == '0 && out_data.decision != DEC_NOSIG
        |-> out_data.energy_tone_a == '0)
        else $error("zero energy with tone energy");

endmodule

bind dual_answer_tone_detector_top dat_assert u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== sim/dat_checker.sv =====
// Checker for the dual answer-tone detector: watches both channels, predicts
// each decision beat and compares it. Depends on dat_pkg.
`timescale 1ns / 1ps
module dat_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  dat_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  dat_pkg::out_beat_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import dat_pkg::*;

    logic signed [31:0] bp_hist [12];
    logic signed [31:0] nt_hist [12];
    logic [31:0] sm_total, sm_a, sm_b;
    logic [15:0] hold_a, hold_b;
    logic [7:0]  ratio_q;
    logic [21:0] energy_floor_q;
    logic [14:0] hold_limit_q;
    out_beat_t   decisions_due [$];
    int          reports;

    function automatic logic signed [31:0] sext16(logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    // one bandpass section; c = a2, b2, a1, b1, b0
    task automatic band_biquad(input int base, input int c0, input int c1, input int c2,
                               input int c3, input int c4, inout logic signed [31:0] x);
        logic [31:0] acc;
        logic signed [31:0] y;
        acc = c4 * x;
        acc = acc + c3 * bp_hist[base];
        acc = acc + c1 * bp_hist[base + 1];
        acc = acc - c2 * bp_hist[base + 2];
        acc = acc - c0 * bp_hist[base + 3];
        y = sext16((acc >> 14) << 1);
        bp_hist[base + 1] = bp_hist[base];
        bp_hist[base] = x;
        bp_hist[base + 3] = bp_hist[base + 2];
        bp_hist[base + 2] = y;
        x = y;
    endtask

    task automatic notch_section(input int base, input int b1, input int a1,
                                 input logic signed [31:0] x, output logic signed [31:0] y);
        logic [31:0] acc;
        acc = x <<< 14;
        acc = acc + b1 * nt_hist[base];
        acc = acc + (nt_hist[base + 1] <<< 14);
        acc = acc - a1 * nt_hist[base + 2];
        acc = acc - 13271 * nt_hist[base + 3];
        y = sext16(acc >> 14);
        nt_hist[base + 1] = nt_hist[base];
        nt_hist[base] = x;
        nt_hist[base + 3] = nt_hist[base + 2];
        nt_hist[base + 2] = y;
    endtask

    function automatic logic [31:0] energy8(logic signed [31:0] v);
        logic [31:0] p;
        p = v * v;
        return p >> 8;
    endfunction

    function automatic logic [31:0] removed_energy(logic [31:0] total, logic signed [31:0] y);
        logic [31:0] f;
        f = energy8(y);
        return (f > total) ? 32'd0 : total - f;
    endfunction

    function automatic logic [31:0] smooth(logic [31:0] acc, logic [31:0] x);
        return (32'd205 * acc + 32'd51 * x) >> 8;
    endfunction

    task automatic detect_sample(input in_beat_t b);
        logic signed [31:0] x, ya, yb, yc;
        logic [31:0] total, thr;
        decision_t   dec;
        out_beat_t   r;
        x = $signed(b.sample) >>> 3;
        hold_a = hold_a + 16'd1;
        hold_b = hold_b + 16'd1;
        band_biquad(0, 6862, -8192, 1495, 0, 8192, x);
        x = x >>> 3;
        band_biquad(4, 7508, 8192, -1140, -16384, 8192, x);
        x = x >>> 3;
        band_biquad(8, 7531, 8192, 4185, 16384, 8192, x);
        notch_section(0, 2571, 2314, x, ya);
        notch_section(4, -5126, -4613, x, yb);
        notch_section(8, 6393, 5753, yb, yc);
        total = energy8(x);
        sm_a = smooth(sm_a, removed_energy(total, ya));
        sm_b = smooth(sm_b, removed_energy(total, yc));
        sm_total = smooth(sm_total, total);
        if (b.last_of_block)
        begin
            thr = (ratio_q * sm_total) >> 8;
            if (sm_total < energy_floor_q)
            begin
                hold_a = '0; hold_b = '0; dec = DEC_NOSIG;
            end
            else if (sm_a > thr)
            begin
                if ($signed(hold_a) < $signed({17'd0, hold_limit_q}))
                begin
                    hold_b = '0; dec = DEC_A;
                end
                else
                begin
                    hold_a = '0; hold_b = '0; dec = DEC_A_CONF;
                end
            end
            else if (sm_b > thr)
            begin
                if ($signed(hold_b) < $signed({17'd0, hold_limit_q}))
                begin
                    hold_a = '0; dec = DEC_B;
                end
                else
                begin
                    hold_a = '0; hold_b = '0; dec = DEC_B_CONF;
                end
            end
            else
            begin
                hold_a = '0; hold_b = '0; dec = DEC_OTHER;
            end
            r.decision = dec;
            r.total_energy = sm_total[21:0];
            r.energy_tone_a = sm_a[21:0];
            r.energy_tone_b = sm_b[21:0];
            decisions_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (bp_hist[i]) bp_hist[i] = 0;
            foreach (nt_hist[i]) nt_hist[i] = 0;
            sm_total = 0; sm_a = 0; sm_b = 0;
            hold_a = 0; hold_b = 0;
            ratio_q = RATIO_RESET;
            energy_floor_q = ENERGY_FLOOR_RESET;
            hold_limit_q = HOLD_LIMIT_RESET;
            decisions_due.delete();
            fail_count = 0;
            pending = 0;
            reports = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATIO:        ratio_q = cfg_data[7:0];
                    REG_ENERGY_FLOOR: energy_floor_q = cfg_data;
                    REG_HOLD_LIMIT:   hold_limit_q = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (decisions_due.size() == 0)
                begin
                    fail_count++;
                    if (reports++ < 10)
                        $display("unexpected beat %p", out_data);
                end
                else
                begin
                    out_beat_t e;
                    e = decisions_due.pop_front();
                    if (e !== out_data)
                    begin
                        fail_count++;
                        if (reports++ < 10)
                            $display("beat differs: expected %p got %p", e, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
                detect_sample(in_data);
            pending = decisions_due.size();
        end
    end
endmodule

// ===== sim/tb_dual_answer_tone_detector_top.sv =====
// Stimulus and verdict for the dual answer-tone detector top.
// Depends on dat_pkg, dual_answer_tone_detector_top and dat_checker.
`timescale 1ns / 1ps
module tb_dual_answer_tone_detector_top;
    import dat_pkg::*;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 0;
    out_beat_t  out_data;
    logic       cfg_we = 0;
    logic [1:0] cfg_index = '0;
    logic [21:0] cfg_data = '0;
    int         fail_count, pending;
    int         cycles = 0;
    bit         hold_off = 0;

    always #2 clk = ~clk;

    dual_answer_tone_detector_top dut (.*);
    dat_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2500000)
        begin
            $display("dual_answer_tone_detector_top: mismatch");
            $finish;
        end
    end

    // receiver: random stall per beat, plus one long hold-off
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if (w != 0 || hold_off)
            begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // valid stays up across back-to-back beats; drop it only for a gap
    task automatic send(input logic signed [15:0] s, input logic last, input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 13) : 0;
        if (w != 0)
        begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= '{sample: s, last_of_block: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [21:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // tone near f Hz at 8 kHz with random amplitude and phase, blocks of blen
    task automatic send_tone(input int n, input real f, input int blen, input bit gaps);
        real amp, ph;
        int v;
        amp = $urandom_range(500, 32000);
        ph = $urandom_range(0, 628) / 100.0;
        for (int i = 0; i < n; i++)
        begin
            v = $rtoi(amp * $sin(ph + 6.2831853 * f * i / 8000.0));
            if ($urandom_range(0, 9) == 0)
                v += $urandom_range(0, 2000) - 1000;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send(v[15:0], (i % blen) == blen - 1, gaps);
        end
    endtask

    initial
    begin
        int mode;
        real freqs [4] = '{2100.0, 1800.0, 2250.0, 1000.0};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        // directed: extremes, then tones under changed ratio, floor and hold settings
        send(16'sh7FFF, 1'b0, 1'b0); send(-16'sh8000, 1'b1, 1'b0);
        send(16'sh0000, 1'b1, 1'b0); send(16'shFFFF, 1'b0, 1'b0);
        send(16'sh5555, 1'b0, 1'b0); send(16'shAAAA, 1'b1, 1'b0);
        send_tone(12, 2100.0, 4, 0);
        send_tone(9, 1800.0, 3, 0);
        drain();
        write_reg(REG_RATIO, 22'd0);
        write_reg(REG_ENERGY_FLOOR, 22'h3FFFFF);
        write_reg(REG_HOLD_LIMIT, 22'd0);
        send_tone(6, 2100.0, 2, 0);
        drain();
        write_reg(REG_ENERGY_FLOOR, 22'd0);
        send_tone(6, 2250.0, 2, 0);
        drain();
        write_reg(REG_RATIO, 22'd255);
        write_reg(REG_HOLD_LIMIT, 22'h7FFF);
        send_tone(6, 1000.0, 3, 0);
        drain();
        // random phases with changing settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_RATIO, 22'($urandom_range(0, 3) == 0 ? 226
                                                              : $urandom_range(0, 255)));
            write_reg(REG_ENERGY_FLOOR, 22'($urandom_range(0, 1) ? $urandom_range(0, 20)
                                                                 : $urandom_range(0, 22'h3FFFFF)));
            write_reg(REG_HOLD_LIMIT, 22'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                               : $urandom_range(0, 32767)));
            if (ph == 3)
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int k = 0; k < 6; k++)
            begin
                mode = $urandom_range(0, 4);
                if (mode < 4)
                    send_tone(30, freqs[mode], $urandom_range(1, 8), ph % 2 == 0);
                else
                    for (int i = 0; i < 30; i++)
                        send(16'($urandom), $urandom_range(0, 3) == 0, ph % 2 == 0);
            end
            drain();
        end
        if (fail_count == 0)
            $display("dual_answer_tone_detector_top: match");
        else
            $display("dual_answer_tone_detector_top: mismatch");
        $finish;
    end
endmodule
